### design/q51_pkg.sv
// ============================================================================
// q51_pkg: shared types and helpers for the Q5_1 block dequantizer
// Item structs, fp16 widening, and the canonical NaN code.
// ============================================================================
package q51_pkg;

	localparam int PairsPerBlock = 16;
	localparam int PairIdxW      = 4;
	localparam logic [31:0] CanonNan = 32'h7FC0_0000;

	typedef struct packed {
		logic [15:0] scale_half;
		logic [15:0] min_half;
		logic [31:0] high_bits;
		logic [63:0] nibbles_first_half;
		logic [63:0] nibbles_second_half;
		logic        row_end_in;
	} blk_in_t;

	typedef struct packed {
		logic [3:0]  pair_index;
		logic [31:0] value_lower;
		logic [31:0] value_upper;
		logic        block_last;
		logic        row_end_out;
	} blk_out_t;

	// pair control that rides along the pipeline
	typedef struct packed {
		logic [3:0] idx;
		logic       last;
		logic       row_end;
	} pair_ctl_t;

	// exact fp16 -> fp32 widening; subnormal normalized by priority search
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic       s;
		logic [4:0] ex;
		logic [9:0] man;
		logic [9:0] m2;
		logic [7:0] e32;
		logic [3:0] lz;
		s   = h[15];
		ex  = h[14:10];
		man = h[9:0];
		lz  = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (man[i]) lz = 4'(9 - i);
		end
		m2  = 10'(man << (lz + 4'd1));
		e32 = 8'(8'd112 - {4'd0, lz});
		if (ex == 5'd0) begin
			if (man == 10'd0) half_to_single = {s, 31'd0};
			else              half_to_single = {s, e32, m2, 13'd0};
		end else if (ex == 5'h1F) begin
			half_to_single = {s, 8'hFF, man, 13'd0};
		end else begin
			half_to_single = {s, 8'(ex) + 8'd112, man, 13'd0};
		end
	endfunction

endpackage

### design/q51_mul.sv
// ============================================================================
// q51_mul: 5-bit integer times fp32 scale, rounded to fp32 (RNE)
// Two register stages: raw product, then normalize and round.
// ============================================================================
module q51_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [4:0]  v,
	input  logic [31:0] scale,
	output logic [31:0] prod
);
	import q51_pkg::*;

	// stage A: integer product and operand class
	logic [28:0] p_s1;
	logic        sgn_s1, zero_s1, inf_s1, nan_s1, vz_s1;
	logic signed [10:0] e_s1;

	logic [23:0] sig;
	logic signed [10:0] e_b;
	logic [4:0] lzs;
	always_comb begin
		lzs = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (scale[i]) lzs = 5'(22 - i);
		end
		if (scale[30:23] == 8'd0) begin
			sig = 24'(scale[22:0] << (lzs + 5'd1));
			e_b = -11'sd127 - 11'(signed'({6'd0, lzs}));
		end else begin
			sig = {1'b1, scale[22:0]};
			e_b = 11'(signed'({3'd0, scale[30:23]})) - 11'sd127;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= {5'd0, sig} * {24'd0, v};
			e_s1    <= e_b;
			sgn_s1  <= scale[31];
			zero_s1 <= (scale[30:0] == 31'd0);
			inf_s1  <= (scale[30:23] == 8'hFF) && (scale[22:0] == 23'd0);
			nan_s1  <= (scale[30:23] == 8'hFF) && (scale[22:0] != 23'd0);
			vz_s1   <= (v == 5'd0);
		end
	end

	// stage B: value = p * 2^(e-23); normalize so leading one at bit 28
	logic [4:0]  lp;
	logic [28:0] pn;
	logic signed [11:0] ee;
	logic [23:0] m;
	logic [6:0]  sh;
	logic [56:0] wide;
	logic        g, st, inc;
	logic [24:0] mr;
	logic [31:0] res;
	always_comb begin
		lp = 5'd0;
		for (int i = 0; i < 29; i++) begin
			if (p_s1[i]) lp = 5'(i);
		end
		pn = p_s1 << (5'd28 - lp);
		// exponent of leading one
		ee = 12'(e_s1) + 12'(signed'({7'd0, lp})) - 12'sd23;
		wide = {pn, 28'd0};
		sh = 7'd0;
		if (ee < -12'sd126) begin
			sh = (ee < -12'sd160) ? 7'd34 : 7'(-12'sd126 - ee);
		end
		wide = wide >> sh;
		m  = wide[56:33];
		g  = wide[32];
		st = |wide[31:0];
		inc = g && (st || m[0]);
		mr = {1'b0, m} + 25'(inc);
		if (nan_s1 || (inf_s1 && vz_s1)) begin
			res = CanonNan;
		end else if (inf_s1) begin
			res = {sgn_s1, 8'hFF, 23'd0};
		end else if (zero_s1 || vz_s1) begin
			res = {sgn_s1, 31'd0};
		end else if (sh != 7'd0) begin
			// subnormal or carried into min normal
			res = {sgn_s1, 8'(mr[23]), mr[22:0]};
		end else if (mr[24]) begin
			res = (ee + 12'sd128 >= 12'sd255) ? {sgn_s1, 8'hFF, 23'd0}
				: {sgn_s1, 8'(ee + 12'sd128), 23'd0};
		end else begin
			res = (ee + 12'sd127 >= 12'sd255) ? {sgn_s1, 8'hFF, 23'd0}
				: {sgn_s1, 8'(ee + 12'sd127), mr[22:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) prod <= res;
	end
endmodule

### design/q51_add.sv
// ============================================================================
// q51_add: fp32 adder, round to nearest even, canonical NaN
// Three stages: align, add and normalize-search, round and pack.
// ============================================================================
module q51_add (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] sum
);
	import q51_pkg::*;

	// stage 1: swap and align (significands with 3 extra bits, sticky)
	logic [31:0] x, y;
	logic [7:0]  ex, ey, d;
	logic [26:0] mx, my, mya;
	logic        spec;
	logic [31:0] sres;
	always_comb begin
		if (a[30:0] >= b[30:0]) begin x = a; y = b; end
		else begin x = b; y = a; end
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx = {x[30:23] != 8'd0, x[22:0], 3'd0};
		my = {y[30:23] != 8'd0, y[22:0], 3'd0};
		d  = ex - ey;
		if (d > 8'd26) mya = {26'd0, |my};
		else mya = (my >> d) | 27'((my & ~(27'h7FFFFFF << d)) != 27'd0);
		spec = 1'b1;
		if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) || (b[30:23] == 8'hFF && b[22:0] != 23'd0))
			sres = CanonNan;
		else if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
			sres = (a[31] == b[31]) ? a : CanonNan;
		else if (a[30:23] == 8'hFF) sres = a;
		else if (b[30:23] == 8'hFF) sres = b;
		else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) sres = {a[31] & b[31], 31'd0};
		else begin spec = 1'b0; sres = 32'd0; end
	end

	logic [26:0] mx_s1, my_s1;
	logic [7:0]  e_s1;
	logic        sg_s1, sub_s1, spec_s1;
	logic [31:0] sres_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= mx; my_s1 <= mya; e_s1 <= ex; sg_s1 <= x[31];
			sub_s1 <= x[31] ^ y[31]; spec_s1 <= spec; sres_s1 <= sres;
		end
	end

	// stage 2: add/subtract and find leading one
	logic [27:0] s;
	logic [4:0]  lp;
	always_comb begin
		s = sub_s1 ? ({1'b0, mx_s1} - {1'b0, my_s1}) : ({1'b0, mx_s1} + {1'b0, my_s1});
		lp = 5'd0;
		for (int i = 0; i < 28; i++) begin
			if (s[i]) lp = 5'(i);
		end
	end

	logic [27:0] s_s2;
	logic [4:0]  lp_s2;
	logic [7:0]  e_s2;
	logic        sg_s2, spec_s2;
	logic [31:0] sres_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			s_s2 <= s; lp_s2 <= lp; e_s2 <= e_s1; sg_s2 <= sg_s1;
			spec_s2 <= spec_s1; sres_s2 <= sres_s1;
		end
	end

	// stage 3: normalize, round, pack. leading one nominally at bit 26.
	logic signed [9:0] ne;
	logic [4:0]  lsh;
	logic [27:0] n;
	logic [23:0] m;
	logic        g, st, inc;
	logic [24:0] mr;
	logic [31:0] res;
	logic [9:0]  re;
	always_comb begin
		n = s_s2; lsh = 5'd0; m = 24'd0; g = 1'b0; st = 1'b0;
		ne = 10'sd0; mr = 25'd0; inc = 1'b0; re = 10'd0;
		if (lp_s2 == 5'd27) begin
			ne = 10'(signed'({2'd0, e_s2})) + 10'sd1;
			m = s_s2[27:4]; g = s_s2[3]; st = |s_s2[2:0];
		end else begin
			lsh = 5'd26 - lp_s2;
			if (10'(signed'({5'd0, lsh})) > 10'(signed'({2'd0, e_s2})) - 10'sd1)
				lsh = 5'(e_s2 - 8'd1);
			n = s_s2 << lsh;
			ne = 10'(signed'({2'd0, e_s2})) - 10'(signed'({5'd0, lsh}));
			m = n[26:3]; g = n[2]; st = |n[1:0];
		end
		inc = g && (st || m[0]);
		mr = {1'b0, m} + 25'(inc);
		if (mr[24]) begin
			re = 10'(ne + 10'sd1); mr = mr >> 1;
		end else begin
			re = (mr[23]) ? 10'(ne) : 10'd0;
		end
		if (spec_s2) res = sres_s2;
		else if (s_s2 == 28'd0) res = 32'd0;
		else if (re >= 10'd255) res = {sg_s2, 8'hFF, 23'd0};
		else res = {sg_s2, re[7:0], mr[22:0]};
	end

	always_ff @(posedge clk) begin
		if (en) sum <= res;
	end
endmodule

### design/q51_seq.sv
// ============================================================================
// q51_seq: block holder and pair sequencer
// Latches one block, then issues its sixteen element pairs, one per cycle.
// ============================================================================
module q51_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  q51_pkg::blk_in_t  blk,
	output logic              busy,
	output logic              vld,
	output logic [4:0]        v_lo,
	output logic [4:0]        v_hi,
	output logic [31:0]       scale_f,
	output logic [31:0]       min_f,
	output q51_pkg::pair_ctl_t ctl
);
	import q51_pkg::*;

	blk_in_t blk_q;
	logic [3:0] idx_q;
	logic       act_q;
	logic [127:0] bytes;
	logic [7:0]   byt;
	logic         accept;

	assign accept = start && !busy;
	// a new block is taken in the cycle its predecessor issues pair 15
	assign busy = act_q && (idx_q != 4'(PairsPerBlock - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= '0;
		end else if (accept) begin
			act_q <= 1'b1;
			idx_q <= '0;
		end else if (act_q) begin
			idx_q <= idx_q + 4'd1;
			if (idx_q == 4'(PairsPerBlock - 1)) act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) blk_q <= blk;
	end

	assign bytes = {blk_q.nibbles_second_half, blk_q.nibbles_first_half};
	assign byt   = bytes[{idx_q, 3'd0} +: 8];
	assign vld   = act_q;
	assign v_lo  = {blk_q.high_bits[{1'b0, idx_q}], byt[3:0]};
	assign v_hi  = {blk_q.high_bits[{1'b1, idx_q}], byt[7:4]};
	assign scale_f = half_to_single(blk_q.scale_half);
	assign min_f   = half_to_single(blk_q.min_half);
	assign ctl.idx = idx_q;
	assign ctl.last = (idx_q == 4'(PairsPerBlock - 1));
	assign ctl.row_end = (idx_q == 4'(PairsPerBlock - 1)) && blk_q.row_end_in;
endmodule

### design/q5_1_block_dequantizer.sv
// ============================================================================
// q5_1_block_dequantizer: Q5_1 block to fp32 pair stream
// One 24-byte block in, sixteen pairs of fp32 elements out (v*scale + min).
// ============================================================================
//
//  port group  dir  handshake            payload
//  ----------  ---  -------------------  --------------------------
//  block in    in   start && !busy       blk   (q51_pkg::blk_in_t)
//  pair out    out  strobe, one cycle    res   (q51_pkg::blk_out_t)
//
// Each item is issued as sixteen pairs: the sequencer issues one element pair per cycle,
// so the single pair port sets the rate. The next item is taken in the cycle
// the previous one issues its last pair, so pairs stream without gaps.
// From issue to strobe a pair passes 2 multiply stages, 3 add stages and
// 1 output register. Reset clears the sequencer and the valid pipe only.
// The receiver cannot stall; the pipe always advances.
//
module q5_1_block_dequantizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  q51_pkg::blk_in_t  blk,
	output logic              strobe,
	output q51_pkg::blk_out_t res
);
	import q51_pkg::*;

	localparam int Lat = 5;

	logic        vld;
	logic [4:0]  v_lo, v_hi;
	logic [31:0] scale_f, min_f;
	pair_ctl_t   ctl;

	q51_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .blk(blk), .busy(busy),
		.vld(vld), .v_lo(v_lo), .v_hi(v_hi), .scale_f(scale_f), .min_f(min_f),
		.ctl(ctl)
	);

	// products, with the offset delayed to line up with them
	logic [31:0] p_lo, p_hi;
	logic [31:0] min_d1, min_d2;

	q51_mul u_mul_lo (.clk(clk), .en(1'b1), .v(v_lo), .scale(scale_f), .prod(p_lo));
	q51_mul u_mul_hi (.clk(clk), .en(1'b1), .v(v_hi), .scale(scale_f), .prod(p_hi));

	always_ff @(posedge clk) begin
		min_d1 <= min_f;
		min_d2 <= min_d1;
	end

	logic [31:0] s_lo, s_hi;
	q51_add u_add_lo (.clk(clk), .en(1'b1), .a(p_lo), .b(min_d2), .sum(s_lo));
	q51_add u_add_hi (.clk(clk), .en(1'b1), .a(p_hi), .b(min_d2), .sum(s_hi));

	// valid and pair control ride alongside the arithmetic
	logic      vld_q [Lat];
	pair_ctl_t ctl_q [Lat];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Lat; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= vld;
			for (int i = 1; i < Lat; i++) vld_q[i] <= vld_q[i-1];
		end
	end
	always_ff @(posedge clk) begin
		ctl_q[0] <= ctl;
		for (int i = 1; i < Lat; i++) ctl_q[i] <= ctl_q[i-1];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= vld_q[Lat-1];
	end
	always_ff @(posedge clk) begin
		res.pair_index  <= ctl_q[Lat-1].idx;
		res.value_lower <= s_lo;
		res.value_upper <= s_hi;
		res.block_last  <= ctl_q[Lat-1].last;
		res.row_end_out <= ctl_q[Lat-1].row_end;
	end
endmodule
